[design/svpwm_pkg.sv]
package svpwm_pkg;

    // voltages are carried internally times 2^KQ
    localparam int KQ = 24;

    // 1/sqrt(3) in q0.24
    localparam logic [KQ-1:0] INV_SQRT3_Q = 24'd9686330;

    typedef enum logic [2:0] {
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5,
        SEC_6 = 3'd6
    } t_sector;

endpackage

[design/svpwm_duty_calculator_top.sv]
// throughput: one item per cycle, the whole pipeline advances unless the
//   output holds a result and i_stall is high
// the depth is set by the restoring dividers, one quotient bit per stage
// reset: i_rst_n synchronous active low, clears every stage valid bit
module svpwm_duty_calculator_top #(
    parameter int VOLT_WIDTH = 16,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [VOLT_WIDTH-1:0] i_u_alpha,
    input  logic [VOLT_WIDTH-1:0] i_u_beta,
    input  logic [VOLT_WIDTH-1:0] i_bus_voltage,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_sector_number,
    output logic [FRAC_BITS:0]    o_active_time_first,
    output logic [FRAC_BITS:0]    o_active_time_second,
    output logic [FRAC_BITS:0]    o_zero_time,
    output logic [FRAC_BITS:0]    o_duty_phase_a,
    output logic [FRAC_BITS:0]    o_duty_phase_b,
    output logic [FRAC_BITS:0]    o_duty_phase_c
);
    import svpwm_pkg::*;

    // scaled voltage widths
    localparam int SW = VOLT_WIDTH + KQ + 3;   // signed sector terms
    localparam int NW = SW - 1;                // clamped terms
    localparam int DW = NW + 3;                // divider operands
    localparam int TW = FRAC_BITS + 1;         // q1.frac times
    localparam int NS = FRAC_BITS + 10;        // pipeline stages

    localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

    typedef struct packed {
        logic [DW:0]          r1;
        logic [DW:0]          r2;
        logic [DW-1:0]        den;
        logic [FRAC_BITS-1:0] q1;
        logic [FRAC_BITS-1:0] q2;
    } t_div;

    typedef struct packed {
        t_sector sector;
        logic    zero;
        logic    one1;
        logic    one2;
    } t_side;

    // whole pipe holds while a finished result waits
    logic          w_adv;
    logic [NS-1:0] r_vld;

    assign w_adv   = !(r_vld[NS-1] && i_stall);
    assign o_stall = !w_adv;
    assign o_valid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // stage 1: beta times 1/sqrt(3)
    logic signed [VOLT_WIDTH-1:0] r1_alpha;
    logic signed [SW-1:0]         r1_ub;
    logic [VOLT_WIDTH-1:0]        r1_vdc;
    logic                         r1_pos;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_alpha <= signed'(i_u_alpha);
            r1_ub    <= SW'(signed'(i_u_beta)) * SW'(signed'({1'b0, INV_SQRT3_Q}));
            r1_vdc   <= i_bus_voltage;
            r1_pos   <= !i_u_beta[VOLT_WIDTH-1] && (i_u_beta != '0);
        end
    end

    // stage 2: sector from the two boundary compares
    logic signed [SW-1:0] w_a;
    logic signed [SW-1:0] w_nub;
    t_sector              n2_sector;
    t_sector              r2_sector;
    logic signed [SW-1:0] r2_a;
    logic signed [SW-1:0] r2_ub;
    logic [VOLT_WIDTH-1:0] r2_vdc;

    assign w_a   = SW'(r1_alpha) <<< KQ;
    assign w_nub = -r1_ub;

    always_comb begin
        if (r1_pos) begin
            if (w_a > r1_ub)       n2_sector = SEC_1;
            else if (w_a < w_nub)  n2_sector = SEC_3;
            else                   n2_sector = SEC_2;
        end else begin
            if (w_a > w_nub)       n2_sector = SEC_6;
            else if (w_a < r1_ub)  n2_sector = SEC_4;
            else                   n2_sector = SEC_5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r2_sector <= n2_sector;
            r2_a      <= w_a;
            r2_ub     <= r1_ub;
            r2_vdc    <= r1_vdc;
        end
    end

    // stage 3: active vector numerators, negative rounding clamped to zero
    logic signed [SW-1:0] w_s1;
    logic signed [SW-1:0] w_s2;
    logic [NW-1:0]        r3_n1;
    logic [NW-1:0]        r3_n2;
    t_sector              r3_sector;
    logic [VOLT_WIDTH-1:0] r3_vdc;

    always_comb begin
        case (r2_sector)
            SEC_1: begin w_s1 = r2_a - r2_ub;   w_s2 = r2_ub <<< 1;      end
            SEC_2: begin w_s1 = r2_a + r2_ub;   w_s2 = r2_ub - r2_a;     end
            SEC_3: begin w_s1 = r2_ub <<< 1;    w_s2 = -r2_a - r2_ub;    end
            SEC_4: begin w_s1 = r2_ub - r2_a;   w_s2 = -(r2_ub <<< 1);   end
            SEC_5: begin w_s1 = -r2_a - r2_ub;  w_s2 = r2_a - r2_ub;     end
            default: begin w_s1 = -(r2_ub <<< 1); w_s2 = r2_a + r2_ub;   end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_n1     <= w_s1[SW-1] ? '0 : w_s1[NW-1:0];
            r3_n2     <= w_s2[SW-1] ? '0 : w_s2[NW-1:0];
            r3_sector <= r2_sector;
            r3_vdc    <= r2_vdc;
        end
    end

    // stage 4: demand sum
    logic [NW:0]           r4_nsum;
    logic [NW-1:0]         r4_n1;
    logic [NW-1:0]         r4_n2;
    t_sector               r4_sector;
    logic [VOLT_WIDTH-1:0] r4_vdc;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_nsum   <= {1'b0, r3_n1} + {1'b0, r3_n2};
            r4_n1     <= r3_n1;
            r4_n2     <= r3_n2;
            r4_sector <= r3_sector;
            r4_vdc    <= r3_vdc;
        end
    end

    // stage 5: overmodulation test, 1.5 * sum against the bus
    logic [DW-1:0]         w_sum3;
    logic [DW-1:0]         w_bus;
    logic                  r5_over;
    logic [NW:0]           r5_nsum;
    logic [NW-1:0]         r5_n1;
    logic [NW-1:0]         r5_n2;
    logic [DW-1:0]         r5_bus;
    t_sector               r5_sector;

    assign w_sum3 = (DW'(r4_nsum) << 1) + DW'(r4_nsum);
    assign w_bus  = DW'(r4_vdc) << (KQ + 1);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_over   <= (r4_vdc == '0) ? (r4_nsum != '0) : (w_sum3 > w_bus);
            r5_nsum   <= r4_nsum;
            r5_n1     <= r4_n1;
            r5_n2     <= r4_n2;
            r5_bus    <= w_bus;
            r5_sector <= r4_sector;
        end
    end

    // stage 6: divider operands, normalize by the sum when over
    logic [DW-1:0] r6_num1;
    logic [DW-1:0] r6_num2;
    logic [DW-1:0] r6_den;
    t_sector       r6_sector;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r5_over) begin
                r6_num1 <= DW'(r5_n1);
                r6_num2 <= DW'(r5_n2);
                r6_den  <= DW'(r5_nsum);
            end else begin
                r6_num1 <= (DW'(r5_n1) << 1) + DW'(r5_n1);
                r6_num2 <= (DW'(r5_n2) << 1) + DW'(r5_n2);
                r6_den  <= r5_bus;
            end
            r6_sector <= r5_sector;
        end
    end

    // stage 7 and on: restoring division, one quotient bit per stage
    t_div  r_dv [0:FRAC_BITS];
    t_side r_sd [0:FRAC_BITS];

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dv[0].r1     <= {1'b0, r6_num1};
            r_dv[0].r2     <= {1'b0, r6_num2};
            r_dv[0].den    <= r6_den;
            r_dv[0].q1     <= '0;
            r_dv[0].q2     <= '0;
            r_sd[0].sector <= r6_sector;
            r_sd[0].zero   <= (r6_den == '0);
            r_sd[0].one1   <= (r6_num1 >= r6_den);
            r_sd[0].one2   <= (r6_num2 >= r6_den);
        end
    end

    for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_div
        logic [DW:0] w_t1;
        logic [DW:0] w_t2;
        logic [DW:0] w_d;
        logic        w_b1;
        logic        w_b2;

        assign w_t1 = r_dv[k-1].r1 << 1;
        assign w_t2 = r_dv[k-1].r2 << 1;
        assign w_d  = {1'b0, r_dv[k-1].den};
        assign w_b1 = (w_t1 >= w_d);
        assign w_b2 = (w_t2 >= w_d);

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dv[k].r1  <= w_b1 ? (w_t1 - w_d) : w_t1;
                r_dv[k].r2  <= w_b2 ? (w_t2 - w_d) : w_t2;
                r_dv[k].den <= r_dv[k-1].den;
                r_dv[k].q1  <= {r_dv[k-1].q1[FRAC_BITS-2:0], w_b1};
                r_dv[k].q2  <= {r_dv[k-1].q2[FRAC_BITS-2:0], w_b2};
                r_sd[k]     <= r_sd[k-1];
            end
        end
    end

    // resolve the special quotients
    logic [TW-1:0] r8_t1;
    logic [TW-1:0] r8_t2;
    t_sector       r8_sector;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_sd[FRAC_BITS].zero) begin
                r8_t1 <= '0;
                r8_t2 <= '0;
            end else begin
                r8_t1 <= r_sd[FRAC_BITS].one1 ? ONE : {1'b0, r_dv[FRAC_BITS].q1};
                r8_t2 <= r_sd[FRAC_BITS].one2 ? ONE : {1'b0, r_dv[FRAC_BITS].q2};
            end
            r8_sector <= r_sd[FRAC_BITS].sector;
        end
    end

    // zero vector time
    logic [TW:0]   w_tsum;
    logic [TW-1:0] r9_t0;
    logic [TW-1:0] r9_t1;
    logic [TW-1:0] r9_t2;
    t_sector       r9_sector;

    assign w_tsum = {1'b0, r8_t1} + {1'b0, r8_t2};

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r9_t0     <= (w_tsum >= {1'b0, ONE}) ? '0 : TW'({1'b0, ONE} - w_tsum);
            r9_t1     <= r8_t1;
            r9_t2     <= r8_t2;
            r9_sector <= r8_sector;
        end
    end

    // symmetric phase duties
    logic [TW-1:0] w_half;
    logic [TW-1:0] w_h1;
    logic [TW-1:0] w_h2;
    logic [TW-1:0] w_h12;
    logic [TW-1:0] n_ta;
    logic [TW-1:0] n_tb;
    logic [TW-1:0] n_tc;

    assign w_half = r9_t0 >> 1;
    assign w_h1   = w_half + r9_t1;
    assign w_h2   = w_half + r9_t2;
    assign w_h12  = w_h1 + r9_t2;

    always_comb begin
        case (r9_sector)
            SEC_1: begin n_ta = w_h12;  n_tb = w_h2;   n_tc = w_half; end
            SEC_2: begin n_ta = w_h1;   n_tb = w_h12;  n_tc = w_half; end
            SEC_3: begin n_ta = w_half; n_tb = w_h12;  n_tc = w_h2;   end
            SEC_4: begin n_ta = w_half; n_tb = w_h1;   n_tc = w_h12;  end
            SEC_5: begin n_ta = w_h2;   n_tb = w_half; n_tc = w_h12;  end
            default: begin n_ta = w_h12; n_tb = w_half; n_tc = w_h1;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_sector_number      <= r9_sector;
            o_active_time_first  <= r9_t1;
            o_active_time_second <= r9_t2;
            o_zero_time          <= r9_t0;
            o_duty_phase_a       <= n_ta;
            o_duty_phase_b       <= n_tb;
            o_duty_phase_c       <= n_tc;
        end
    end

endmodule

[design/svpwm_chk.sv]
module svpwm_chk #(
    parameter int FRAC_BITS  = 16
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [2:0]            o_sector_number,
    input logic [FRAC_BITS:0]    o_active_time_first,
    input logic [FRAC_BITS:0]    o_active_time_second,
    input logic [FRAC_BITS:0]    o_zero_time,
    input logic [FRAC_BITS:0]    o_duty_phase_a,
    input logic [FRAC_BITS:0]    o_duty_phase_b,
    input logic [FRAC_BITS:0]    o_duty_phase_c
);
    import svpwm_pkg::*;

    localparam logic [FRAC_BITS+1:0] ONE = (FRAC_BITS+2)'(1) << FRAC_BITS;

    logic [FRAC_BITS+1:0] w_act;
    logic [FRAC_BITS:0]   w_half;

    assign w_act  = {1'b0, o_active_time_first} + {1'b0, o_active_time_second};
    assign w_half = o_zero_time >> 1;

    // a waiting result stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_sector: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_sector_number == SEC_1) || (o_sector_number == SEC_2) ||
                    (o_sector_number == SEC_3) || (o_sector_number == SEC_4) ||
                    (o_sector_number == SEC_5) || (o_sector_number == SEC_6))
        else $error("sector out of range");

    // zero time completes the period
    a_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((w_act + (FRAC_BITS+2)'(o_zero_time)) == ONE) ||
                    ((o_zero_time == '0) && (w_act >= ONE)))
        else $error("times do not fill the period");

    // one phase always sits at half the zero time
    a_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_duty_phase_a == w_half) || (o_duty_phase_b == w_half) ||
                    (o_duty_phase_c == w_half))
        else $error("no phase at the lower zero segment");

endmodule

bind svpwm_duty_calculator_top svpwm_chk #(
    .FRAC_BITS (FRAC_BITS)
) u_svpwm_chk (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import svpwm_pkg::*;

    localparam int VW        = 16;
    localparam int FB        = 16;
    localparam int ONE       = 1 << FB;
    localparam int LATENCY   = FB + 10;
    localparam int N_RANDOM  = 1730;
    localparam int STALL_MAX = 4000;

    // one set of duties as the block reports it
    typedef struct {
        t_sector     sec;
        logic [FB:0] t1;
        logic [FB:0] t2;
        logic [FB:0] t0;
        logic [FB:0] ta;
        logic [FB:0] tb;
        logic [FB:0] tc;
    } duty_set_t;

    // directed row: reference pair, bus, and a typed result where it is obvious
    typedef struct {
        logic signed [VW-1:0] al;
        logic signed [VW-1:0] be;
        logic [VW-1:0]        vdc;
        bit                   known;
        duty_set_t            want;
    } row_t;

    localparam duty_set_t NONE = '{SEC_1, 0, 0, 0, 0, 0, 0};

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [VW-1:0] i_u_alpha;
    logic signed [VW-1:0] i_u_beta;
    logic [VW-1:0]        i_bus_voltage;
    logic                 o_valid;
    logic                 i_stall;
    logic [2:0]           o_sector_number;
    logic [FB:0]          o_active_time_first;
    logic [FB:0]          o_active_time_second;
    logic [FB:0]          o_zero_time;
    logic [FB:0]          o_duty_phase_a;
    logic [FB:0]          o_duty_phase_b;
    logic [FB:0]          o_duty_phase_c;

    duty_set_t pending_duties[$];
    int        n_errors;
    int        quiet_cycles;
    bit        steady;    // no idling on either side while set

    svpwm_duty_calculator_top #(
        .VOLT_WIDTH(VW),
        .FRAC_BITS (FB)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_u_alpha           (i_u_alpha),
        .i_u_beta            (i_u_beta),
        .i_bus_voltage       (i_bus_voltage),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_sector_number     (o_sector_number),
        .o_active_time_first (o_active_time_first),
        .o_active_time_second(o_active_time_second),
        .o_zero_time         (o_zero_time),
        .o_duty_phase_a      (o_duty_phase_a),
        .o_duty_phase_b      (o_duty_phase_b),
        .o_duty_phase_c      (o_duty_phase_c)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // floor(num * 2^FB / den) by restoring division, saturating at one
    function automatic logic [FB:0] frac_ratio(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = 0;
        r = num;
        if (den == 0) return 0;
        if (r >= den) return ONE;
        for (int i = 0; i < FB; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q = q | 1;
            end
        end
        return q[FB:0];
    endfunction

    // sector, active times with overmodulation scaling, zero time and duties
    function automatic duty_set_t svpwm_duties(logic signed [VW-1:0] al,
                                               logic signed [VW-1:0] be,
                                               logic [VW-1:0] vdc);
        duty_set_t   d;
        longint      a;
        longint      ub;
        longint      s1;
        longint      s2;
        logic [63:0] n1;
        logic [63:0] n2;
        logic [63:0] nsum;
        logic [63:0] full;
        logic [FB:0] half;
        bit          over;
        a  = longint'(al) * (longint'(1) << KQ);
        ub = longint'(be) * longint'(INV_SQRT3_Q);
        if (be > 0)
            d.sec = (a > ub) ? SEC_1 : ((a < -ub) ? SEC_3 : SEC_2);
        else
            d.sec = (a > -ub) ? SEC_6 : ((a < ub) ? SEC_4 : SEC_5);
        case (d.sec)
            SEC_1: begin s1 = a - ub;  s2 = 2 * ub;  end
            SEC_2: begin s1 = a + ub;  s2 = ub - a;  end
            SEC_3: begin s1 = 2 * ub;  s2 = -a - ub; end
            SEC_4: begin s1 = ub - a;  s2 = -2 * ub; end
            SEC_5: begin s1 = -a - ub; s2 = a - ub;  end
            default: begin s1 = -2 * ub; s2 = a + ub; end
        endcase
        // small negative numerators from rounding are clamped
        n1   = (s1 < 0) ? 0 : s1;
        n2   = (s2 < 0) ? 0 : s2;
        nsum = n1 + n2;
        full = (64'(vdc) * 2) << KQ;
        over = (vdc == 0) ? (nsum > 0) : (3 * nsum > full);
        if (over) begin
            d.t1 = frac_ratio(n1, nsum);
            d.t2 = frac_ratio(n2, nsum);
        end else if (vdc == 0) begin
            d.t1 = 0;
            d.t2 = 0;
        end else begin
            d.t1 = frac_ratio(3 * n1, full);
            d.t2 = frac_ratio(3 * n2, full);
        end
        d.t0 = (d.t1 + d.t2 >= ONE) ? 0 : ONE - d.t1 - d.t2;
        half = d.t0 >> 1;
        case (d.sec)
            SEC_1: begin d.ta = half + d.t1 + d.t2; d.tb = half + d.t2;        d.tc = half; end
            SEC_2: begin d.ta = half + d.t1;        d.tb = half + d.t1 + d.t2; d.tc = half; end
            SEC_3: begin d.ta = half; d.tb = half + d.t1 + d.t2; d.tc = half + d.t2;        end
            SEC_4: begin d.ta = half; d.tb = half + d.t1;        d.tc = half + d.t1 + d.t2; end
            SEC_5: begin d.ta = half + d.t2; d.tb = half; d.tc = half + d.t1 + d.t2;        end
            default: begin d.ta = half + d.t1 + d.t2; d.tb = half; d.tc = half + d.t1;     end
        endcase
        return d;
    endfunction

    // present one item, with random idle cycles first, and wait for it to be taken
    task automatic send_item(logic signed [VW-1:0] al, logic signed [VW-1:0] be,
                             logic [VW-1:0] vdc, bit known, duty_set_t want);
        while (!steady && $urandom_range(99) < 20) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_u_alpha     <= al;
        i_u_beta      <= be;
        i_bus_voltage <= vdc;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_duties.push_back(known ? want : svpwm_duties(al, be, vdc));
    endtask

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endtask

    // random receiver stall
    always @(posedge i_clk) begin
        i_stall <= steady ? 1'b0 : ($urandom_range(99) < 20);
    end

    // result checker, oldest expectation first
    always @(posedge i_clk) begin
        duty_set_t d;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_duties.size() == 0) begin
                $error("result item with no expectation waiting");
                n_errors++;
            end else begin
                d = pending_duties.pop_front();
                check_field("sector_number",      d.sec, o_sector_number);
                check_field("active_time_first",  d.t1,  o_active_time_first);
                check_field("active_time_second", d.t2,  o_active_time_second);
                check_field("zero_time",          d.t0,  o_zero_time);
                check_field("duty_phase_a",       d.ta,  o_duty_phase_a);
                check_field("duty_phase_b",       d.tb,  o_duty_phase_b);
                check_field("duty_phase_c",       d.tc,  o_duty_phase_c);
            end
        end
    end

    // watchdog: cycles with no item moving on either side
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // directed rows: zero reference, extremes, every sector, clamp and overmodulation
    row_t directed[] = '{
        '{16'sd0,      16'sd0,      16'd1000,  1'b1,
          '{SEC_5, 0, 0, ONE, ONE/2, ONE/2, ONE/2}},
        '{16'sd0,      16'sd0,      16'd65535, 1'b1,
          '{SEC_5, 0, 0, ONE, ONE/2, ONE/2, ONE/2}},
        '{16'sd32767,  16'sd0,      16'd1,     1'b1,
          '{SEC_6, 0, ONE, 0, ONE, 0, 0}},
        '{-16'sd32768, 16'sd0,      16'd1,     1'b1,
          '{SEC_4, ONE, 0, 0, 0, ONE, ONE}},
        '{16'sd32767,  16'sd32767,  16'd65535, 1'b0, NONE},
        '{-16'sd32768, -16'sd32768, 16'd65535, 1'b0, NONE},
        '{16'sd32767,  -16'sd32768, 16'd1,     1'b0, NONE},
        '{-16'sd32768, 16'sd32767,  16'd32768, 1'b0, NONE},
        '{16'sd100,    16'sd50,     16'd400,   1'b0, NONE},
        '{16'sd0,      16'sd100,    16'd400,   1'b0, NONE},
        '{-16'sd100,   16'sd50,     16'd400,   1'b0, NONE},
        '{-16'sd100,   -16'sd50,    16'd400,   1'b0, NONE},
        '{16'sd0,      -16'sd100,   16'd400,   1'b0, NONE},
        '{16'sd100,    -16'sd50,    16'd400,   1'b0, NONE},
        // near the sector borders, alpha about beta/sqrt3
        '{16'sd577,    16'sd1000,   16'd2000,  1'b0, NONE},
        '{16'sd578,    16'sd1000,   16'd2000,  1'b0, NONE},
        '{-16'sd577,   -16'sd1000,  16'd2000,  1'b0, NONE},
        '{16'sd1,      -16'sd1,     16'd1,     1'b0, NONE},
        '{-16'sd1,     16'sd1,      16'd65535, 1'b0, NONE},
        // just inside and past the hexagon edge
        '{16'sd999,    16'sd0,      16'd1500,  1'b0, NONE},
        '{16'sd1001,   16'sd0,      16'd1500,  1'b0, NONE},
        '{16'sd20000,  16'sd20000,  16'd65535, 1'b0, NONE}
    };

    // random reference, mostly scaled to the bus so both linear and overmodulated occur
    task automatic send_random();
        logic signed [VW-1:0] al;
        logic signed [VW-1:0] be;
        logic [VW-1:0]        vdc;
        int                   span;
        case ($urandom_range(9))
            0: begin
                al  = $urandom;
                be  = $urandom;
                vdc = $urandom_range(65535, 1);
            end
            1: begin
                al  = $urandom_range(8) - 4;
                be  = $urandom_range(8) - 4;
                vdc = $urandom_range(16, 1);
            end
            default: begin
                vdc  = $urandom_range(65535, 1);
                span = (vdc * 7 / 10 > 32767) ? 32767 : vdc * 7 / 10 + 1;
                al   = $urandom_range(2 * span) - span;
                be   = $urandom_range(2 * span) - span;
            end
        endcase
        send_item(al, be, vdc, 1'b0, NONE);
    endtask

    initial begin
        n_errors      = 0;
        quiet_cycles  = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_u_alpha     = '0;
        i_u_beta      = '0;
        i_bus_voltage = 16'd1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[k])
            send_item(directed[k].al, directed[k].be, directed[k].vdc,
                      directed[k].known, directed[k].want);

        for (int n = 0; n < N_RANDOM; n++) begin
            // a stretch with no idling on either side
            steady = (n >= 600 && n < 900);
            // let the pipeline drain completely once mid-run
            if (n == 1200) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_duties.size() != 0) @(posedge i_clk);
            end
            send_random();
        end
        i_valid <= 1'b0;

        while (pending_duties.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 14) @(posedge i_clk);
        if (n_errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
